// ----- src/shd84_pkg.sv -----
// ----------------------------------------------------------------------------
// shd84_pkg
// Types and constants for the extended Hamming(8,4) SECDED frame decoder.
// ----------------------------------------------------------------------------
package shd84_pkg;

  localparam int unsigned CwWidth    = 8;
  localparam int unsigned NibWidth   = 4;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = 9;

  // saturation point of the correction counter
  localparam logic [CountWidth-1:0] CountMax      = 9'd256;
  // reset value of the correction limit register
  localparam logic [CountWidth-1:0] MaxCorrReset  = 9'd3;
  // mask for the seven hamming bits below the overall parity bit
  localparam logic [CwWidth-1:0]    Hamming7Mask  = 8'h7F;

  // result kinds
  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // end-of-frame verdict
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ODD    = 2'd1,
    ST_UNCORR = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  // one result item
  typedef struct packed {
    logic                  kind;
    logic [ByteWidth-1:0]  data_byte;
    status_e               status;
    logic [CountWidth-1:0] corrections;
    logic                  last_result;
  } result_t;

endpackage

// ----- src/shd84_in_if.sv -----
// ----------------------------------------------------------------------------
// shd84_in_if
// Codeword request channel: valid/ready handshake with codeword payload.
// ----------------------------------------------------------------------------
interface shd84_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] codeword;
  logic       frame_end;

  modport source (output valid, output codeword, output frame_end, input ready);
  modport sink   (input valid, input codeword, input frame_end, output ready);
endinterface

// ----- src/shd84_out_if.sv -----
// ----------------------------------------------------------------------------
// shd84_out_if
// Result request channel: valid/ready handshake with decoded byte or status.
// ----------------------------------------------------------------------------
interface shd84_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic [8:0] corrections;
  logic       last_result;

  modport source (output valid, output kind, output data_byte, output status,
                  output corrections, output last_result, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input corrections, input last_result, output ready);
endinterface

// ----- src/secded_hamming84_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// secded_hamming84_frame_decoder
// Extended Hamming(8,4) decoder pairing nibbles into bytes, with frame status.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register, decoded from there,
//   and its results are presented from the result buffer once it advances.
// Throughput: one codeword per cycle while results drain; a pair that closes a
//   frame yields two results, queued together in the 2-entry result buffer.
// Reset: control and frame state clear; the correction limit returns to 3.
module secded_hamming84_frame_decoder
  import shd84_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CountWidth-1:0] cfg_wdata_i,
  shd84_in_if.sink              in_i,
  shd84_out_if.source           out_o
);

  // input register
  logic               in_vld_q;
  logic [CwWidth-1:0] cw_q;
  logic               fend_q;

  // frame state
  logic                  second_half_q;
  logic [NibWidth-1:0]   held_q;
  logic [CountWidth-1:0] cnt_q;
  logic                  failed_q;
  logic [CountWidth-1:0] max_corr_q;

  // result buffer
  result_t    buf_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] count_q;

  // decode signals
  logic [CwWidth-1:0]    low7;
  logic [2:0]            syn;
  logic                  par;
  logic [CwWidth-1:0]    flip;
  logic [CwWidth-1:0]    fixed_w;
  logic [NibWidth-1:0]   nib;
  logic                  is_fixed;
  logic                  is_fatal;
  logic                  failed_n;
  logic [CountWidth-1:0] cnt_n;
  logic                  emit_data;
  logic                  emit_stat;
  logic [1:0]            n_res;
  status_e               st;
  result_t               res_data;
  result_t               res_stat;
  result_t               r0;
  logic                  adv;
  logic                  pop;

  // syndrome and overall parity
  always_comb begin
    low7 = cw_q & Hamming7Mask;
    syn[0] = low7[0] ^ low7[2] ^ low7[4] ^ low7[6];
    syn[1] = low7[1] ^ low7[2] ^ low7[5] ^ low7[6];
    syn[2] = low7[3] ^ low7[4] ^ low7[5] ^ low7[6];
    par    = ^cw_q;
    flip   = '0;
    if (par && (syn != 3'd0)) begin
      flip = 8'd1 << (syn - 3'd1);
    end
    fixed_w  = low7 ^ flip;
    nib      = {fixed_w[2], fixed_w[4], fixed_w[5], fixed_w[6]};
    is_fixed = par;
    is_fatal = !par && (syn != 3'd0);
  end

  // frame bookkeeping and result assembly
  always_comb begin
    failed_n = failed_q | is_fatal;
    cnt_n    = cnt_q;
    if (is_fixed && (cnt_q != CountMax)) begin
      cnt_n = cnt_q + 9'd1;
    end
    emit_data = second_half_q && !failed_n;
    emit_stat = fend_q;
    n_res     = {1'b0, emit_data} + {1'b0, emit_stat};

    if (!second_half_q) begin
      st = ST_ODD;
    end else if (failed_n) begin
      st = ST_UNCORR;
    end else if (cnt_n > max_corr_q) begin
      st = ST_REJECT;
    end else begin
      st = ST_OK;
    end

    res_data.kind        = KindData;
    res_data.data_byte   = {held_q, nib};
    res_data.status      = ST_OK;
    res_data.corrections = '0;
    res_data.last_result = !emit_stat;

    res_stat.kind        = KindStatus;
    res_stat.data_byte   = '0;
    res_stat.status      = st;
    res_stat.corrections = cnt_n;
    res_stat.last_result = 1'b1;

    r0 = emit_data ? res_data : res_stat;
  end

  // advance when the buffer has room for every result of this codeword,
  // counting the slot freed by a result leaving in the same cycle
  assign adv = in_vld_q &&
               (({1'b0, count_q} + {1'b0, n_res}) <= (3'd2 + {2'b0, pop}));
  assign pop = out_o.valid && out_o.ready;

  assign in_i.ready = !in_vld_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cw_q   <= in_i.codeword;
      fend_q <= in_i.frame_end;
    end
  end

  // correction limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_corr_q <= MaxCorrReset;
    end else if (cfg_we_i) begin
      max_corr_q <= cfg_wdata_i;
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_half_q <= 1'b0;
      held_q        <= '0;
      cnt_q         <= '0;
      failed_q      <= 1'b0;
    end else if (adv) begin
      if (fend_q) begin
        second_half_q <= 1'b0;
        held_q        <= '0;
        cnt_q         <= '0;
        failed_q      <= 1'b0;
      end else begin
        second_half_q <= !second_half_q;
        if (!second_half_q) begin
          held_q <= nib;
        end
        cnt_q    <= cnt_n;
        failed_q <= failed_n;
      end
    end
  end

  // result buffer pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (adv) begin
        wp_q <= wp_q ^ n_res[0];
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      count_q <= count_q + (adv ? n_res : 2'd0) - {1'b0, pop};
    end
  end

  // result buffer storage
  always_ff @(posedge clk_i) begin
    if (adv && (n_res != 2'd0)) begin
      buf_q[wp_q] <= r0;
      if (n_res == 2'd2) begin
        buf_q[!wp_q] <= res_stat;
      end
    end
  end

  // output drive
  assign out_o.valid       = (count_q != 2'd0);
  assign out_o.kind        = buf_q[rp_q].kind;
  assign out_o.data_byte   = buf_q[rp_q].data_byte;
  assign out_o.status      = buf_q[rp_q].status;
  assign out_o.corrections = buf_q[rp_q].corrections;
  assign out_o.last_result = buf_q[rp_q].last_result;

  // buffer never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("result buffer overfilled");

  // data items carry no status or count
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == KindData)) |->
      ((out_o.status == ST_OK) && (out_o.corrections == '0)))
    else $error("data item with status fields set");

  // frame end leaves the frame state cleared
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && fend_q) |=> (!second_half_q && (cnt_q == '0) && !failed_q))
    else $error("frame state not cleared after frame end");

  // count never passes the saturation point
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountMax)
    else $error("correction count beyond saturation");

endmodule

// ----- verif/secded_hamming84_frame_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// secded_hamming84_frame_decoder_tb
// Self-checking bench for the extended Hamming(8,4) frame decoder. A table of
// hand-picked codewords is run first: clean words, lone parity errors, a
// single error in every bit, double errors and odd frames. Random frames then
// run under several correction limits. Each accepted codeword is fed to a
// behavioural decoder that queues the bytes and frame verdicts it should
// produce. The sender works in bursts, the receiver stalls on changing
// patterns, and one long hold-off fills the block.
// ----------------------------------------------------------------------------
module secded_hamming84_frame_decoder_tb;
  import shd84_pkg::*;

  localparam int unsigned ItemsPerPhase = 171;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned NumVectors    = 24;
  localparam int unsigned LongFrameLen  = 260;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned HoldCycles    = 96;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned MaxReports    = 10;

  // one row of the directed table, with the frame verdict where it is obvious
  typedef struct packed {
    logic [CwWidth-1:0]    cw;
    logic                  fe;
    logic                  typed;
    status_e               st;
    logic [CountWidth-1:0] corr;
  } vec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CountWidth-1:0] cfg_wdata_i;

  shd84_in_if  in_if ();
  shd84_out_if out_if ();

  secded_hamming84_frame_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // decoder state mirrored by the bench
  logic                  pair_open  = 1'b0;
  logic [NibWidth-1:0]   high_nib   = '0;
  logic [CountWidth-1:0] corr_count = '0;
  logic                  frame_bad  = 1'b0;
  logic [CountWidth-1:0] corr_limit = MaxCorrReset;

  result_t     expected_q[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          long_hold  = 1'b0;

  // directed codewords: clean, parity-only, every single-bit error, double errors
  vec_t dir_tbl [NumVectors] = '{
    '{8'h00, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'hFF, 1'b1, 1'b1, ST_OK,     9'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h7F, 1'b1, 1'b1, ST_OK,     9'd2},
    '{8'h01, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h02, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h04, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h08, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h10, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h20, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h40, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h00, 1'b1, 1'b1, ST_REJECT, 9'd7},
    '{8'hFF, 1'b1, 1'b1, ST_ODD,    9'd0},
    '{8'h03, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'hFF, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'hFF, 1'b1, 1'b1, ST_UNCORR, 9'd0},
    '{8'h03, 1'b1, 1'b1, ST_ODD,    9'd0},
    '{8'h01, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h02, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h04, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h08, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h03, 1'b0, 1'b0, ST_OK,     9'd0},
    '{8'h10, 1'b1, 1'b1, ST_UNCORR, 9'd5}
  };

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // build a clean codeword from a data nibble (d1 in the msb)
  function automatic logic [CwWidth-1:0] build_codeword(input logic [NibWidth-1:0] n);
    logic [6:0] h;
    h[2] = n[3];
    h[4] = n[2];
    h[5] = n[1];
    h[6] = n[0];
    h[0] = n[3] ^ n[2] ^ n[0];
    h[1] = n[3] ^ n[1] ^ n[0];
    h[3] = n[2] ^ n[1] ^ n[0];
    return {^h, h};
  endfunction

  // syndrome decode of one codeword
  function automatic logic [NibWidth-1:0] fix_codeword(input logic [CwWidth-1:0] cw,
                                                       output logic fixed,
                                                       output logic fatal);
    logic [CwWidth-1:0] h;
    logic [2:0]         syn;
    logic               par;
    h      = cw & Hamming7Mask;
    syn[0] = h[0] ^ h[2] ^ h[4] ^ h[6];
    syn[1] = h[1] ^ h[2] ^ h[5] ^ h[6];
    syn[2] = h[3] ^ h[4] ^ h[5] ^ h[6];
    par    = ^cw;
    fixed  = par;
    fatal  = !par && (syn != 3'd0);
    if (par && (syn != 3'd0)) begin
      h[syn - 3'd1] = ~h[syn - 3'd1];
    end
    return {h[2], h[4], h[5], h[6]};
  endfunction

  // advance the frame state by one codeword and queue the results it causes
  task automatic predict_word(input logic [CwWidth-1:0] cw, input logic fe);
    result_t             outs [2];
    int                  n;
    logic [NibWidth-1:0] nib;
    logic                fixed;
    logic                fatal;
    status_e             verdict;
    n   = 0;
    nib = fix_codeword(cw, fixed, fatal);
    if (fatal) frame_bad = 1'b1;
    if (fixed && (corr_count < CountMax)) corr_count = corr_count + 9'd1;
    // pair nibbles into bytes, high nibble first
    if (!pair_open) begin
      high_nib  = nib;
      pair_open = 1'b1;
    end else begin
      if (!frame_bad) begin
        outs[n] = '{KindData, {high_nib, nib}, ST_OK, '0, 1'b0};
        n++;
      end
      pair_open = 1'b0;
    end
    // frame verdict and restart
    if (fe) begin
      if (pair_open) verdict = ST_ODD;
      else if (frame_bad) verdict = ST_UNCORR;
      else if (corr_count > corr_limit) verdict = ST_REJECT;
      else verdict = ST_OK;
      outs[n] = '{KindStatus, 8'h00, verdict, corr_count, 1'b0};
      n++;
      pair_open  = 1'b0;
      high_nib   = '0;
      corr_count = '0;
      frame_bad  = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) outs[i].last_result = 1'b1;
      expected_q.push_back(outs[i]);
    end
  endtask

  // offer one codeword request, with random gaps between bursts
  task automatic send_word(input logic [CwWidth-1:0] cw, input logic fe);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    in_if.valid     <= 1'b1;
    in_if.codeword  <= cw;
    in_if.frame_end <= fe;
    do @(posedge clk_i); while (!in_if.ready);
    predict_word(cw, fe);
    items_sent++;
    burst_left--;
  endtask

  // random frame: clean words with single, double or arbitrary corruption
  task automatic send_frame(input int unsigned len, input int unsigned err_pct);
    logic [CwWidth-1:0] cw;
    int unsigned        r;
    int unsigned        b0;
    int unsigned        b1;
    for (int unsigned i = 0; i < len; i++) begin
      cw = build_codeword(4'($urandom_range(0, 15)));
      r  = $urandom_range(0, 99);
      if (r < err_pct) begin
        cw[$urandom_range(0, 7)] ^= 1'b1;
      end else if (r < err_pct + err_pct / 4) begin
        b0     = $urandom_range(0, 7);
        b1     = (b0 + $urandom_range(1, 7)) % 8;
        cw[b0] = ~cw[b0];
        cw[b1] = ~cw[b1];
      end else if (r >= 97) begin
        cw = 8'($urandom_range(0, 255));
      end
      send_word(cw, i == len - 1);
    end
  endtask

  // wait until every expected result is out and the pipeline is quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [CountWidth-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    corr_limit = v;
  endtask

  // stimulus
  initial begin
    logic [CountWidth-1:0] lims [NumPhases];
    int unsigned           len;
    int unsigned           pct;
    lims = '{9'd0, CountMax, 9'd1, 9'd255, 9'd0, MaxCorrReset};
    lims[4] = 9'($urandom_range(0, 256));
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_if.valid     <= 1'b0;
    in_if.codeword  <= '0;
    in_if.frame_end <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset limit
    foreach (dir_tbl[i]) begin
      send_word(dir_tbl[i].cw, dir_tbl[i].fe);
      if (dir_tbl[i].typed) begin
        void'(expected_q.pop_back());
        expected_q.push_back('{KindStatus, 8'h00, dir_tbl[i].st, dir_tbl[i].corr, 1'b1});
      end
    end

    // random frames, one limit per phase
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      settle();
      set_limit(lims[phase]);
      if (phase == 2) long_hold = 1'b1;
      // saturating count, accepted at the top limit and rejected just below
      if (lims[phase] >= 9'd255) send_frame(LongFrameLen, 100);
      while (items_sent < NumVectors + (phase + 1) * ItemsPerPhase) begin
        len = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 9) : 2 * $urandom_range(1, 6);
        case ($urandom_range(0, 2))
          0:       pct = 0;
          1:       pct = 10;
          default: pct = 40;
        endcase
        send_frame(len, pct);
      end
    end

    settle();
    if (expected_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS secded_hamming84_frame_decoder");
    end else begin
      $display("FAIL secded_hamming84_frame_decoder");
    end
    $finish;
  end

  // receiver: rotating stall patterns, plus one long hold-off
  initial begin
    logic [7:0]  pattern;
    int unsigned left;
    pattern = 8'hFF;
    left    = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        if (left == 0) begin
          case ($urandom_range(0, 3))
            0, 1:    pattern = 8'hFF;
            2:       pattern = 8'($urandom_range(1, 255));
            default: pattern = 8'h11;
          endcase
          left = $urandom_range(16, 64);
        end
        out_if.ready <= pattern[0];
        pattern = {pattern[0], pattern[7:1]};
        left--;
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected result: kind %0d byte %02h status %0d corr %0d last %0d",
                   out_if.kind, out_if.data_byte, out_if.status, out_if.corrections,
                   out_if.last_result);
        end
      end else begin
        e = expected_q.pop_front();
        if ((e.kind !== out_if.kind) || (e.data_byte !== out_if.data_byte) ||
            (e.status !== out_if.status) || (e.corrections !== out_if.corrections) ||
            (e.last_result !== out_if.last_result)) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("result mismatch: exp kind %0d byte %02h status %0d corr %0d last %0d",
                     e.kind, e.data_byte, e.status, e.corrections, e.last_result);
            $display("                 got kind %0d byte %02h status %0d corr %0d last %0d",
                     out_if.kind, out_if.data_byte, out_if.status, out_if.corrections,
                     out_if.last_result);
          end
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request accepted for %0d cycles", IdleLimit);
    $display("FAIL secded_hamming84_frame_decoder");
    $finish;
  end

endmodule

// ----- files.f -----
src/shd84_pkg.sv
src/shd84_in_if.sv
src/shd84_out_if.sv
src/secded_hamming84_frame_decoder.sv
verif/secded_hamming84_frame_decoder_tb.sv
